>>> rtl/core/b64sc_pkg.sv
// Shared types, constants and alphabet helpers for the base64 stream codec.
// No dependencies; imported by the front, queue, back and top modules.
package b64sc_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [6:0] VALUE_INVALID = 7'd64;

    // One queue entry: up to four result items from one input item.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      cnt_m1;
        logic            last;
        logic            has_data;
        logic            halted;
    } b64sc_cmd_t;

    function automatic logic [7:0] b64sc_enc_char(input logic [5:0] v);
        logic [7:0] ve;
        ve = {2'b00, v};
        if (v < 6'd26)      return CHAR_UPPER_A + ve;
        else if (v < 6'd52) return CHAR_LOWER_A + ve - 8'd26;
        else if (v < 6'd62) return CHAR_DIGIT_0 + ve - 8'd52;
        else if (v == 6'd62) return CHAR_PLUS;
        else                return CHAR_SLASH;
    endfunction

    function automatic logic [6:0] b64sc_dec_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = c - CHAR_UPPER_A;
            return d[6:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = c - CHAR_LOWER_A + 8'd26;
            return d[6:0];
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            d = c - CHAR_DIGIT_0 + 8'd52;
            return d[6:0];
        end else if (c == CHAR_PLUS) begin
            return 7'd62;
        end else if (c == CHAR_SLASH) begin
            return 7'd63;
        end else begin
            return VALUE_INVALID;
        end
    endfunction

endpackage

>>> rtl/core/base64_stream_codec.sv
// Base64 encoder/decoder, standard alphabet, one item per cycle at the input.
// Latency: an accepted item is written into the queue, then its first result item is loaded into the output register.
// Throughput: one input item per cycle while the queue has room; the output
// port moves one result item per cycle while m_tready is high. Encoding gives one or two result items
// per byte (three or four on a final byte that needs padding) and decoding at most one per character.
// Reset: mode returns to encode, message state clears, queue and output empty.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,    // mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,        // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,        // out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser         // {halted, has_data}
);
    import b64sc_pkg::*;

    b64sc_cmd_t push_cmd, head_cmd;
    logic       push, full, pop, head_valid, in_accept;

    assign s_tready = !full;
    assign in_accept = s_tvalid && s_tready;

    b64sc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    b64sc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    b64sc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/b64sc_front.sv
// Front end: holds mode and message state, takes one input item per cycle when
// accepted, pushing a queue entry (decode: byte or last). Depends on b64sc_pkg.
module b64sc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  push,
    output b64sc_pkg::b64sc_cmd_t push_cmd
);
    import b64sc_pkg::*;

    logic        mode_reg;
    logic [11:0] acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [1:0]  cm_reg, cm_next;
    logic        stop_reg, stop_next;

    logic [5:0]  keep;
    logic [11:0] enc_acc;
    logic [5:0]  e_c0, e_c1, e_left;
    logic [1:0]  e_nchar;
    logic [2:0]  e_pend;
    logic [1:0]  cm1, cm2, pad;
    logic        has_left;
    logic [2:0]  total;
    logic [6:0]  dv;
    logic [11:0] dec_acc;
    logic [3:0]  dp;
    logic        emit;
    logic [2:0]  d_pend;
    logic [7:0]  d_byte;

    always_comb begin
        keep = acc_reg[5:0] & 6'((7'd1 << pend_reg) - 7'd1);

        enc_acc = {keep[3:0], in_byte};
        e_c1 = 6'd0;
        case (pend_reg)
            3'd2: begin
                e_c0 = enc_acc[9:4];
                e_nchar = 2'd1;
                e_pend = 3'd4;
            end
            3'd4: begin
                e_c0 = enc_acc[11:6];
                e_c1 = enc_acc[5:0];
                e_nchar = 2'd2;
                e_pend = 3'd0;
            end
            default: begin
                e_c0 = enc_acc[7:2];
                e_nchar = 2'd1;
                e_pend = 3'd2;
            end
        endcase
        e_left = (e_pend == 3'd4) ? {enc_acc[3:0], 2'b00} : {enc_acc[1:0], 4'b0000};
        has_left = in_last && (e_pend != 3'd0);
        cm1 = cm_reg + e_nchar;
        cm2 = cm1 + {1'b0, has_left};
        pad = in_last ? (2'd0 - cm2) : 2'd0;
        total = {1'b0, e_nchar} + {2'b00, has_left} + {1'b0, pad};

        dv = b64sc_dec_value(in_byte);
        dec_acc = {keep, dv[5:0]};
        dp = {1'b0, pend_reg} + 4'd6;
        emit = !stop_reg && !dv[6] && (dp >= 4'd8);
        d_pend = emit ? 3'(dp - 4'd8) : dp[2:0];
        case (d_pend)
            3'd2:    d_byte = dec_acc[9:2];
            3'd4:    d_byte = dec_acc[11:4];
            default: d_byte = dec_acc[7:0];
        endcase

        acc_next = acc_reg;
        pend_next = pend_reg;
        cm_next = cm_reg;
        stop_next = stop_reg;
        push_cmd = '0;
        push_cmd.last = in_last;

        if (mode_reg == MODE_ENCODE) begin
            push = in_accept;
            push_cmd.data[0] = b64sc_enc_char(e_c0);
            push_cmd.data[1] = (e_nchar == 2'd2) ? b64sc_enc_char(e_c1) :
                               has_left ? b64sc_enc_char(e_left) : CHAR_PAD;
            push_cmd.data[2] = CHAR_PAD;
            push_cmd.data[3] = CHAR_PAD;
            push_cmd.cnt_m1 = (total > 3'd4) ? 2'd3 : 2'(total - 3'd1);
            push_cmd.has_data = 1'b1;
            acc_next = enc_acc;
            pend_next = e_pend;
            cm_next = cm1;
        end else begin
            push = in_accept && (emit || in_last);
            push_cmd.data[0] = emit ? d_byte : 8'd0;
            push_cmd.has_data = emit;
            push_cmd.halted = !emit && (stop_reg || dv[6]);
            if (!stop_reg) begin
                if (dv[6]) begin
                    stop_next = 1'b1;
                end else begin
                    acc_next = dec_acc;
                    pend_next = d_pend;
                end
            end
        end

        if (in_last) begin
            acc_next = 12'd0;
            pend_next = 3'd0;
            cm_next = 2'd0;
            stop_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
            acc_reg <= 12'd0;
            pend_reg <= 3'd0;
            cm_reg <= 2'd0;
            stop_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
            acc_reg <= 12'd0;
            pend_reg <= 3'd0;
            cm_reg <= 2'd0;
            stop_reg <= 1'b0;
        end else if (in_accept) begin
            acc_reg <= acc_next;
            pend_reg <= pend_next;
            cm_reg <= cm_next;
            stop_reg <= stop_next;
        end
    end

endmodule

>>> rtl/core/b64sc_queue.sv
// Short FIFO of queue entries between the front and back ends.
// Depends on b64sc_pkg.
module b64sc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64sc_pkg::b64sc_cmd_t push_cmd,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output b64sc_pkg::b64sc_cmd_t head_cmd
);
    import b64sc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64sc_cmd_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/b64sc_back.sv
// Back end: walks the head queue entry one result item per cycle, while the
// output is not stalled, into the output register. Depends on b64sc_pkg.
module b64sc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  b64sc_pkg::b64sc_cmd_t head_cmd,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [1:0]            m_tuser
);
    import b64sc_pkg::*;

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [1:0] user_reg;
    logic       load, final_slot;

    assign load = head_valid && (!valid_reg || m_tready);
    assign final_slot = (idx_reg == head_cmd.cnt_m1);
    assign pop = load && final_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg <= final_slot ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= head_cmd.data[idx_reg];
            last_reg <= head_cmd.last && final_slot;
            user_reg <= {head_cmd.halted, head_cmd.has_data};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;
    assign m_tlast = last_reg;
    assign m_tuser = user_reg;

endmodule
